[rtl/core/glw_pkg.sv]
`timescale 1ns / 1ps

package glw_pkg;

   localparam int MAX_ORDER = 64;
   localparam int ORDER_W   = 7;
   localparam int ORDER_MIN = 2;
   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(2);

   localparam int NODE_W    = 48;
   localparam int NODE_FRAC = 46;
   localparam int WEIGHT_W  = 48;

   localparam int K_W    = $clog2(MAX_ORDER + 1);
   localparam int FRAC_W = 44;
   localparam int XMAG_W = 44;
   localparam int QMAG_W = 51;
   localparam int DMAG_W = 45;
   localparam int NQ_W   = K_W + QMAG_W;

   localparam int WORD_W = 64;
   localparam int HALF_W = WORD_W / 2;
   localparam int PROD_W = 2 * WORD_W;

   localparam int DIV_STEPS = WEIGHT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int NUM_SHIFT = 43;

   localparam logic [WORD_W-1:0] ONE_Q  = WORD_W'(1) << FRAC_W;
   localparam logic [QMAG_W-1:0] QCLAMP = QMAG_W'(1) << (QMAG_W - 1);

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_STEP,
      ST_STEP_MUL,
      ST_STEP_T1,
      ST_STEP_T2,
      ST_RCP,
      ST_RCP_MUL,
      ST_FIX1,
      ST_FIX2,
      ST_FIN_XP,
      ST_FIN_XP_MUL,
      ST_FIN_Q,
      ST_FIN_XX,
      ST_FIN_XX_MUL,
      ST_FIN_D,
      ST_FIN_NQ,
      ST_FIN_SQ,
      ST_FIN_SQ_MUL,
      ST_FIN_CHK,
      ST_DIV_WAIT
   } glw_state_type;

endpackage

[rtl/core/glw_mul.sv]
`timescale 1ns / 1ps

module glw_mul import glw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] a,
   input  logic [WORD_W-1:0] b,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   localparam int SH_W = $clog2(PROD_W);

   logic [WORD_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   logic [HALF_W-1:0] a_half, b_half;
   logic [WORD_W-1:0] pp;
   logic [1:0]        psum;
   logic [SH_W-1:0]   shamt;

   assign a_half = cnt_ff[1] ? a_ff[WORD_W-1:HALF_W] : a_ff[HALF_W-1:0];
   assign b_half = cnt_ff[0] ? b_ff[WORD_W-1:HALF_W] : b_ff[HALF_W-1:0];
   assign pp     = a_half * b_half;
   assign psum   = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
   assign shamt  = SH_W'(psum) << $clog2(HALF_W);

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + (PROD_W'(pp) << shamt);
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[rtl/core/glw_div.sv]
`timescale 1ns / 1ps

module glw_div import glw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PROD_W-1:0]   num,
   input  logic [PROD_W-1:0]   den,
   output logic                done,
   output logic [WEIGHT_W-1:0] quotient
);

   logic [PROD_W-1:0]    rem_ff, rem_in, den_ff, den_in;
   logic [WEIGHT_W-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   logic [PROD_W-1:0] shifted;
   logic              fits;

   assign shifted = rem_ff << 1;
   assign fits    = shifted >= den_ff;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (shifted - den_ff) : shifted;
         quo_in = {quo_ff[WEIGHT_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/core/gauss_legendre_weight_core.sv]
`timescale 1ns / 1ps

// Gauss-Legendre weight of one node x for the order n held in the order register.
// Requests: drive req_node (signed Q1.46) with start high while busy is low; the
// request is taken at that edge; busy rises for an in-range node until its reply.
// Results: rsp_weight (unsigned Q2.46, saturating) and rsp_status come with a
// one-cycle rsp_valid strobe; there is no backpressure, the receiver must take it.
// Configuration: csr_wr_en with csr_wr_data writes the order; write only while idle.
// A node with magnitude at or beyond one is answered from idle with status set.
// Otherwise each recurrence step takes two passes through the shared 64x64 multiplier
// (four 32x32 partial products each) plus small-constant multiply and reciprocal
// correction steps; the tail adds three more multiplier passes and, unless the weight
// saturates, a restoring divider for the 48-bit quotient.
// A new request may be taken in the cycle the strobe is high, but not while one is in
// flight. Reset clears the sequencer, drops any request in flight and sets the
// order to 2.

module gauss_legendre_weight_core import glw_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [NODE_W-1:0]   req_node,
   output logic                       rsp_valid,
   output logic        [WEIGHT_W-1:0] rsp_weight,
   output logic                       rsp_status,
   input  logic                       csr_wr_en,
   input  logic        [ORDER_W-1:0]  csr_wr_data
);

   function automatic logic signed [WORD_W-1:0] qround(input logic [PROD_W-1:0] prod,
                                                        input logic neg);
      logic [PROD_W-1:0] sum;
      logic [WORD_W-1:0] r;
      sum = prod + (PROD_W'(1) << (FRAC_W - 1));
      if (sum[PROD_W-1:FRAC_W+WORD_W-1] != '0) begin
         r = {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
         r = {1'b0, sum[FRAC_W+WORD_W-2:FRAC_W]};
      end
      return neg ? -r : r;
   endfunction

   glw_state_type state_ff, state_in;

   logic [ORDER_W-1:0]          order_ff, order_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [WEIGHT_W-1:0]         rsp_weight_ff, rsp_weight_in;
   logic                        rsp_status_ff, rsp_status_in;

   logic [XMAG_W-1:0]           x_mag_ff, x_mag_in;
   logic                        x_neg_ff, x_neg_in;
   logic [K_W-1:0]              n_ff, n_in, k_ff, k_in;
   logic signed [WORD_W-1:0]    p_ff, p_in, p1_ff, p1_in, pm2_ff, pm2_in;
   logic signed [WORD_W-1:0]    t_ff, t_in, qm_ff, qm_in;
   logic [WORD_W-1:0]           est_ff, est_in;
   logic [K_W:0]                rem_ff, rem_in;
   logic                        mneg_ff, mneg_in;
   logic [QMAG_W-1:0]           uq_ff, uq_in;
   logic [DMAG_W-1:0]           d_ff, d_in;
   logic [NQ_W-1:0]             nq_ff, nq_in;

   logic                        mul_start, mul_done;
   logic [WORD_W-1:0]           mul_a, mul_b;
   logic [PROD_W-1:0]           mul_prod;
   logic                        div_start, div_done;
   logic [PROD_W-1:0]           div_num;
   logic [WEIGHT_W-1:0]         div_quo;

   logic [WORD_W-1:0]           recip_tab [2**K_W];

   logic [NODE_W-1:0]           node_mag;
   logic                        node_bad;
   logic [K_W-1:0]              n_clamped;
   logic [WORD_W-1:0]           x_word, p_mag, t_mag, q_mag, rem_wide, q_step;
   logic signed [WORD_W-1:0]    qd, dd;
   logic [K_W:0]                k2m1, km1;

   for (genvar g = 0; g < 2**K_W; g++) begin : g_rcp
      localparam logic [PROD_W-1:0] RCP_FULL =
         (g < ORDER_MIN || g > MAX_ORDER) ? PROD_W'(0) : (PROD_W'(1) << WORD_W) / PROD_W'(g);
      assign recip_tab[g] = RCP_FULL[WORD_W-1:0];
   end

   glw_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   glw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (mul_prod),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign node_mag = req_node[NODE_W-1] ? NODE_W'(-req_node) : NODE_W'(req_node);
   assign node_bad = node_mag[NODE_W-1:NODE_FRAC] != '0;
   assign x_word   = WORD_W'(x_mag_ff);
   assign p_mag    = p_ff[WORD_W-1] ? WORD_W'(-p_ff) : WORD_W'(p_ff);
   assign t_mag    = t_ff[WORD_W-1] ? WORD_W'(-t_ff) : WORD_W'(t_ff);
   assign k2m1     = {k_ff, 1'b0} - (K_W+1)'(1);
   assign km1      = {1'b0, k_ff} - (K_W+1)'(1);
   assign rem_wide = t_mag - est_ff * WORD_W'(k_ff);
   assign q_step   = est_ff + WORD_W'(rem_ff >= {1'b0, k_ff});
   assign qd       = p1_ff - qm_ff;
   assign q_mag    = qd[WORD_W-1] ? WORD_W'(-qd) : WORD_W'(qd);
   assign dd       = $signed(ONE_Q) - qm_ff;
   assign div_num  = PROD_W'(d_ff) << NUM_SHIFT;

   always_comb begin
      if (int'(order_ff) < ORDER_MIN) begin
         n_clamped = K_W'(ORDER_MIN);
      end else if (int'(order_ff) > MAX_ORDER) begin
         n_clamped = K_W'(MAX_ORDER);
      end else begin
         n_clamped = K_W'(order_ff);
      end
   end

   assign order_in = csr_wr_en ? csr_wr_data : order_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = 1'b0;
      rsp_weight_in = rsp_weight_ff;
      rsp_status_in = rsp_status_ff;
      x_mag_in      = x_mag_ff;
      x_neg_in      = x_neg_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      p_in          = p_ff;
      p1_in         = p1_ff;
      pm2_in        = pm2_ff;
      t_in          = t_ff;
      qm_in         = qm_ff;
      est_in        = est_ff;
      rem_in        = rem_ff;
      mneg_in       = mneg_ff;
      uq_in         = uq_ff;
      d_in          = d_ff;
      nq_in         = nq_ff;
      mul_start     = 1'b0;
      mul_a         = x_word;
      mul_b         = p_mag;
      div_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (node_bad) begin
                  rsp_valid_in  = 1'b1;
                  rsp_weight_in = '0;
                  rsp_status_in = STATUS_RANGE;
               end else begin
                  x_mag_in = node_mag[NODE_FRAC-1:NODE_FRAC-XMAG_W];
                  x_neg_in = req_node[NODE_W-1];
                  n_in     = n_clamped;
                  k_in     = K_W'(ORDER_MIN);
                  p1_in    = ONE_Q;
                  p_in     = req_node[NODE_W-1]
                             ? -WORD_W'(node_mag[NODE_FRAC-1:NODE_FRAC-XMAG_W])
                             : WORD_W'(node_mag[NODE_FRAC-1:NODE_FRAC-XMAG_W]);
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            mul_start = 1'b1;
            mneg_in   = x_neg_ff ^ p_ff[WORD_W-1];
            pm2_in    = p1_ff;
            p1_in     = p_ff;
            state_in  = ST_STEP_MUL;
         end
         ST_STEP_MUL: begin
            if (mul_done) begin
               qm_in    = qround(mul_prod, mneg_ff);
               state_in = ST_STEP_T1;
            end
         end
         ST_STEP_T1: begin
            t_in     = qm_ff * $signed({1'b0, k2m1});
            state_in = ST_STEP_T2;
         end
         ST_STEP_T2: begin
            t_in     = t_ff - pm2_ff * $signed({1'b0, km1});
            state_in = ST_RCP;
         end
         ST_RCP: begin
            mul_start = 1'b1;
            mul_a     = t_mag;
            mul_b     = recip_tab[k_ff];
            state_in  = ST_RCP_MUL;
         end
         ST_RCP_MUL: begin
            if (mul_done) begin
               est_in   = mul_prod[PROD_W-1:WORD_W];
               state_in = ST_FIX1;
            end
         end
         ST_FIX1: begin
            rem_in   = rem_wide[K_W:0];
            state_in = ST_FIX2;
         end
         ST_FIX2: begin
            p_in = t_ff[WORD_W-1] ? -q_step : q_step;
            if (k_ff == n_ff) begin
               state_in = ST_FIN_XP;
            end else begin
               k_in     = k_ff + K_W'(1);
               state_in = ST_STEP;
            end
         end
         ST_FIN_XP: begin
            mul_start = 1'b1;
            mneg_in   = x_neg_ff ^ p_ff[WORD_W-1];
            state_in  = ST_FIN_XP_MUL;
         end
         ST_FIN_XP_MUL: begin
            if (mul_done) begin
               qm_in    = qround(mul_prod, mneg_ff);
               state_in = ST_FIN_Q;
            end
         end
         ST_FIN_Q: begin
            uq_in    = (q_mag > WORD_W'(QCLAMP)) ? QCLAMP : q_mag[QMAG_W-1:0];
            state_in = ST_FIN_XX;
         end
         ST_FIN_XX: begin
            mul_start = 1'b1;
            mul_b     = x_word;
            mneg_in   = 1'b0;
            state_in  = ST_FIN_XX_MUL;
         end
         ST_FIN_XX_MUL: begin
            if (mul_done) begin
               qm_in    = qround(mul_prod, mneg_ff);
               state_in = ST_FIN_D;
            end
         end
         ST_FIN_D: begin
            if (dd[WORD_W-1] || dd == '0) begin
               d_in = DMAG_W'(1);
            end else begin
               d_in = dd[DMAG_W-1:0];
            end
            state_in = ST_FIN_NQ;
         end
         ST_FIN_NQ: begin
            nq_in    = NQ_W'(n_ff) * NQ_W'(uq_ff);
            state_in = ST_FIN_SQ;
         end
         ST_FIN_SQ: begin
            mul_start = 1'b1;
            mul_a     = WORD_W'(nq_ff);
            mul_b     = WORD_W'(nq_ff);
            state_in  = ST_FIN_SQ_MUL;
         end
         ST_FIN_SQ_MUL: begin
            if (mul_done) begin
               state_in = ST_FIN_CHK;
            end
         end
         ST_FIN_CHK: begin
            if (mul_prod == '0 || div_num >= mul_prod) begin
               rsp_valid_in  = 1'b1;
               rsp_weight_in = '1;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               rsp_valid_in  = 1'b1;
               rsp_weight_in = div_quo;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= ORDER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_weight_ff <= rsp_weight_in;
      rsp_status_ff <= rsp_status_in;
      x_mag_ff      <= x_mag_in;
      x_neg_ff      <= x_neg_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      p_ff          <= p_in;
      p1_ff         <= p1_in;
      pm2_ff        <= pm2_in;
      t_ff          <= t_in;
      qm_ff         <= qm_in;
      est_ff        <= est_in;
      rem_ff        <= rem_in;
      mneg_ff       <= mneg_in;
      uq_ff         <= uq_in;
      d_ff          <= d_in;
      nq_ff         <= nq_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_weight = rsp_weight_ff;
   assign rsp_status = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_STEP_MUL || state_ff == ST_RCP_MUL ||
                    state_ff == ST_FIN_XP_MUL || state_ff == ST_FIN_XX_MUL ||
                    state_ff == ST_FIN_SQ_MUL))
      else $error("multiplier finished outside a wait state");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (k_ff <= n_ff && int'(n_ff) >= ORDER_MIN &&
                                 int'(n_ff) <= MAX_ORDER))
      else $error("recurrence index beyond order");

   a_good_request_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !node_bad) |=> (busy && !rsp_valid))
      else $error("in-range request did not start the sequencer");
`endif

endmodule

[tb/sv/glw_checker.sv]
`timescale 1ns / 1ps

module glw_checker import glw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [NODE_W-1:0]   req_node,
   input  logic                rsp_valid,
   input  logic [WEIGHT_W-1:0] rsp_weight,
   input  logic                rsp_status,
   input  logic                csr_wr_en,
   input  logic [ORDER_W-1:0]  csr_wr_data,
   output int                  mismatches,
   output int                  pending
);

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic                status;
   } weight_type;

   localparam longint ONE_FIX = longint'(ONE_Q);

   weight_type         weights_due[$];
   logic [ORDER_W-1:0] order_q;

   // q44 product, round half away from zero, saturating
   function automatic longint fix_mul(input longint a, input longint b);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] prod;
      logic [63:0]  r;
      logic         neg;
      neg  = (a < 0) != (b < 0);
      ma   = (a < 0) ? 64'(-a) : 64'(a);
      mb   = (b < 0) ? 64'(-b) : 64'(b);
      prod = {64'b0, ma} * {64'b0, mb} + (128'd1 << 43);
      if (prod[127:107] != '0) begin
         r = 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
         r = prod[107:44];
      end
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic weight_type legendre_weight(input logic [NODE_W-1:0] node,
                                                  input logic [ORDER_W-1:0] order_reg);
      logic              neg;
      logic [NODE_W-1:0] m;
      int                n;
      longint            x;
      longint            p;
      longint            p1;
      longint            pm2;
      longint            t;
      longint            q;
      longint            d;
      logic [63:0]       uq;
      logic [127:0]      den;
      logic [127:0]      num;
      logic [175:0]      quo;
      weight_type        r;
      neg = node[NODE_W-1];
      m   = neg ? -node : node;
      if (m >= (NODE_W'(1) << NODE_FRAC)) begin
         r.weight = '0;
         r.status = STATUS_RANGE;
         return r;
      end
      n = int'(order_reg);
      if (n < ORDER_MIN) n = ORDER_MIN;
      if (n > MAX_ORDER) n = MAX_ORDER;
      x = longint'(m >> 2);
      if (neg) x = -x;
      p1 = ONE_FIX;
      p  = x;
      for (longint k = 2; k <= n; k++) begin
         pm2 = p1;
         p1  = p;
         t   = (2 * k - 1) * fix_mul(x, p1) - (k - 1) * pm2;
         p   = t / k;
      end
      q  = p1 - fix_mul(x, p);
      uq = (q < 0) ? 64'(-q) : 64'(q);
      if (uq > 64'(QCLAMP)) uq = 64'(QCLAMP);
      d = ONE_FIX - fix_mul(x, x);
      if (d < 1) d = 1;
      den = 128'(uq) * 128'(uq) * 128'(n * n);
      num = 128'(d) << NUM_SHIFT;
      if (den == '0 || num >= den) begin
         r.weight = '1;
      end else begin
         quo      = ({48'b0, num} << WEIGHT_W) / {48'b0, den};
         r.weight = quo[WEIGHT_W-1:0];
      end
      r.status = STATUS_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      weight_type want;
      int         errs;
      errs = 0;
      if (reset) begin
         order_q <= ORDER_RESET;
         weights_due.delete();
         pending <= 0;
      end else begin
         if (rsp_valid) begin
            if (weights_due.size() == 0) begin
               $error("unexpected weight %h status %b", rsp_weight, rsp_status);
               errs++;
            end else begin
               want = weights_due.pop_front();
               if (rsp_weight !== want.weight) begin
                  $error("weight: expected %h, got %h", want.weight, rsp_weight);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %b, got %b", want.status, rsp_status);
                  errs++;
               end
            end
         end
         if (start && !busy) weights_due.push_back(legendre_weight(req_node, order_q));
         if (csr_wr_en) order_q <= csr_wr_data;
         pending <= weights_due.size();
      end
      if (errs != 0) mismatches <= mismatches + errs;
   end

   final begin
      if (weights_due.size() != 0)
         $error("%0d weights never returned", weights_due.size());
   end

endmodule

[tb/sv/tb_gauss_legendre_weight_core.sv]
`timescale 1ns / 1ps

module tb_gauss_legendre_weight_core;
   import glw_pkg::*;

   localparam logic [NODE_W-1:0] NODE_ONE = NODE_W'(1) << NODE_FRAC;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [NODE_W-1:0]   req_node = '0;
   logic                rsp_valid;
   logic [WEIGHT_W-1:0] rsp_weight;
   logic                rsp_status;
   logic                csr_wr_en = 1'b0;
   logic [ORDER_W-1:0]  csr_wr_data = '0;
   int                  mismatches;
   int                  pending;
   int                  sent_count = 0;
   int                  outside_count = 0;
   int                  order_writes = 0;

   always #5 clock = ~clock;

   gauss_legendre_weight_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_node    (req_node),
      .rsp_valid   (rsp_valid),
      .rsp_weight  (rsp_weight),
      .rsp_status  (rsp_status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   glw_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_node    (req_node),
      .rsp_valid   (rsp_valid),
      .rsp_weight  (rsp_weight),
      .rsp_status  (rsp_status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   task automatic send_request(input logic [NODE_W-1:0] node, input int idle);
      logic [NODE_W-1:0] m;
      m = node[NODE_W-1] ? -node : node;
      repeat (idle) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_node <= node;
      do @(posedge clock); while (busy);
      sent_count++;
      if (m >= NODE_ONE) outside_count++;
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_order(input logic [ORDER_W-1:0] order_val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= order_val;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      order_writes++;
   endtask

   function automatic int idle_burst();
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 12);
      return 0;
   endfunction

   // out of range, near +-1, tiny, or anywhere inside
   function automatic logic [NODE_W-1:0] random_node();
      logic [63:0]       raw;
      logic [NODE_W-1:0] mag_v;
      int                pick;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         raw[46] = ~raw[47];
         return raw[NODE_W-1:0];
      end
      if (pick < 22) mag_v = NODE_ONE - NODE_W'($urandom_range(1, 1 << 20));
      else if (pick < 36) mag_v = NODE_W'(raw[19:0]);
      else mag_v = NODE_W'(raw[45:0]);
      return raw[63] ? -mag_v : mag_v;
   endfunction

   initial begin
      logic [ORDER_W-1:0] phase_orders[12];
      bit                 no_idle;
      phase_orders = '{7'd3, 7'd64, 7'd5, 7'd0, 7'd12, 7'd127,
                       7'd2, 7'd9, 7'd1, 7'd65, 7'd4, 7'd6};
      phase_orders[10] = ORDER_W'($urandom_range(2, 20));
      phase_orders[11] = ORDER_W'($urandom_range(2, 20));
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // order 2 straight out of reset
      send_request('0, 0);
      send_request(NODE_W'(1), 0);
      send_request(-NODE_W'(1), 0);
      send_request(NODE_W'(3), 0);
      send_request(NODE_W'(4), 0);
      send_request(NODE_ONE - 1, 0);
      send_request(-(NODE_ONE - 1), 0);
      send_request(NODE_ONE, 0);
      send_request(-NODE_ONE, 0);
      send_request(48'h7FFF_FFFF_FFFF, 0);
      send_request(48'h8000_0000_0000, 0);
      send_request(NODE_ONE >> 1, 0);
      send_request(-(NODE_ONE >> 1), 0);
      drain();
      set_order(7'd64);
      send_request('0, 0);
      send_request(NODE_ONE - 1, 0);
      send_request(-(NODE_ONE - 1), 0);
      send_request(random_node(), 0);
      drain();
      set_order(7'd0);
      send_request(NODE_ONE >> 2, 0);
      drain();
      set_order(7'd1);
      send_request(-(NODE_ONE >> 2), 0);
      drain();
      set_order(7'd127);
      send_request(NODE_ONE >> 3, 0);
      drain();
      set_order(7'd65);
      send_request(-(NODE_ONE >> 3), 0);
      drain();
      set_order(7'd63);
      send_request('0, 0);

      for (int ph = 0; ph < 12; ph++) begin
         drain();
         set_order(phase_orders[ph]);
         no_idle = (ph == 4) || (ph >= 10);
         for (int i = 0; i < 50; i++) begin
            if (ph == 2 && i == 25) drain();
            send_request(random_node(), no_idle ? 0 : idle_burst());
         end
      end
      drain();
      repeat (20) @(posedge clock);

      $display("run covered %0d requests, %0d of them with |x| >= 1,", sent_count,
               outside_count);
      $display("over %0d order writes including clamped orders 0, 1, 65 and 127",
               order_writes);
      if (mismatches == 0) begin
         $display("tb_gauss_legendre_weight_core: clean");
      end else begin
         $display("tb_gauss_legendre_weight_core: errors");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("tb_gauss_legendre_weight_core: errors");
      $finish;
   end

endmodule
